// ===== design/tmlg_pkg.sv =====
// ----------------------------------------------------------------------------
// Trimmed-mean level grader package
// Shared widths, constants and register codes for the level grader core.
// ----------------------------------------------------------------------------
package tmlg_pkg;

   localparam int SAMPLE_W          = 12;
   localparam int MEAN_W            = 12;
   localparam int HEIGHT_W          = 7;
   localparam int LEVEL_W           = 2;
   localparam int THRESH_W          = 7;
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 7;
   localparam int KEPT_LOG2_DEFAULT = 3;

   // Height in cm is (mean * 6399) >> 18, close to mean * 3.3 * 30.3 / 4096.
   localparam int                  HEIGHT_MUL_W = 13;
   localparam logic [HEIGHT_MUL_W-1:0] HEIGHT_MUL = 13'd6399;
   localparam int                  HEIGHT_SHIFT = 18;
   localparam int                  PROD_W       = MEAN_W + HEIGHT_MUL_W;

   localparam logic [THRESH_W-1:0] THRESH_LOW_RESET  = 7'd30;
   localparam logic [THRESH_W-1:0] THRESH_MID_RESET  = 7'd50;
   localparam logic [THRESH_W-1:0] THRESH_HIGH_RESET = 7'd70;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD_LOW  = 2'd0,
      CSR_THRESHOLD_MID  = 2'd1,
      CSR_THRESHOLD_HIGH = 2'd2
   } csr_index_type;

   typedef enum logic [LEVEL_W-1:0] {
      LEVEL_0 = 2'd0,
      LEVEL_1 = 2'd1,
      LEVEL_2 = 2'd2,
      LEVEL_3 = 2'd3
   } level_type;

endpackage

// ===== design/tmlg_if.sv =====
// ----------------------------------------------------------------------------
// Trimmed-mean level grader channels
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
interface tmlg_req_if;
   import tmlg_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface tmlg_rsp_if;
   import tmlg_pkg::*;

   logic                valid;
   logic                ready;
   logic [MEAN_W-1:0]   mean_code;
   logic [HEIGHT_W-1:0] height_cm;
   logic [LEVEL_W-1:0]  level;
   logic                level_changed;
   logic                level_rose;

   modport source (output valid, output mean_code, output height_cm, output level,
                   output level_changed, output level_rose, input ready);
   modport sink   (input valid, input mean_code, input height_cm, input level,
                   input level_changed, input level_rose, output ready);
endinterface

// ===== design/trimmed_mean_level_grader_core.sv =====
// Last sample of a window: input register, then mean register, then response register.
// Throughput: one sample per cycle; one response per window of 2**KEPT_LOG2 + 2 samples.
// This rate holds unless responses stall; it is set by the accumulator sum/min/max update.
// Reset (synchronous, active high) empties the pipeline, clears the window and
// restores the default thresholds; the first window after reset is never flagged.
// ----------------------------------------------------------------------------
// Trimmed-mean level grader core
// Windowed trimmed mean of converter samples, converted to height and graded.
// ----------------------------------------------------------------------------
module trimmed_mean_level_grader_core #(
   parameter int KEPT_LOG2 = tmlg_pkg::KEPT_LOG2_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   tmlg_req_if.sink                         req_if,
   tmlg_rsp_if.source                       rsp_if,
   input  logic                             csr_we,
   input  logic [tmlg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tmlg_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tmlg_pkg::*;

   localparam int                WINDOW_LEN = (1 << KEPT_LOG2) + 2;
   localparam int                COUNT_W    = $clog2(WINDOW_LEN);
   localparam int                SUM_W      = SAMPLE_W + COUNT_W;
   localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(WINDOW_LEN - 1);

   // Configuration registers.
   logic [THRESH_W-1:0] thresh_low_ff, thresh_low_in;
   logic [THRESH_W-1:0] thresh_mid_ff, thresh_mid_in;
   logic [THRESH_W-1:0] thresh_high_ff, thresh_high_in;

   // Input register.
   logic                in_valid_ff, in_valid_in;
   logic [SAMPLE_W-1:0] in_sample_ff, in_sample_in;

   // Window accumulator.
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] min_ff, min_in;
   logic [SAMPLE_W-1:0] max_ff, max_in;

   // Mean register.
   logic                mean_valid_ff, mean_valid_in;
   logic [MEAN_W-1:0]   mean_ff, mean_in;

   // Grading history.
   logic [LEVEL_W-1:0]  prev_level_ff, prev_level_in;
   logic                first_done_ff, first_done_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [MEAN_W-1:0]   rsp_mean_ff, rsp_mean_in;
   logic [HEIGHT_W-1:0] rsp_height_ff, rsp_height_in;
   logic [LEVEL_W-1:0]  rsp_level_ff, rsp_level_in;
   logic                rsp_changed_ff, rsp_changed_in;
   logic                rsp_rose_ff, rsp_rose_in;

   logic                out_free;
   logic                mean_take;
   logic                mean_move;
   logic                window_end;
   logic                in_consume;
   logic                req_accept;
   logic [SUM_W-1:0]    sum_next;
   logic [SAMPLE_W-1:0] min_next;
   logic [SAMPLE_W-1:0] max_next;
   logic [SUM_W-1:0]    trimmed_sum;
   logic [PROD_W-1:0]   product;
   logic [HEIGHT_W-1:0] height;
   level_type           level;
   logic                changed;

   // Handshake: each stage moves when the stage after it is free or draining.
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign mean_take  = !mean_valid_ff || out_free;
   assign mean_move  = mean_valid_ff && out_free;
   assign window_end = (count_ff == LAST_COUNT);
   assign in_consume = in_valid_ff && (!window_end || mean_take);
   assign req_if.ready = !in_valid_ff || in_consume;
   assign req_accept = req_if.valid && req_if.ready;

   // Configuration writes.
   always_comb begin
      thresh_low_in  = thresh_low_ff;
      thresh_mid_in  = thresh_mid_ff;
      thresh_high_in = thresh_high_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_THRESHOLD_LOW:  thresh_low_in  = csr_wdata;
            CSR_THRESHOLD_MID:  thresh_mid_in  = csr_wdata;
            CSR_THRESHOLD_HIGH: thresh_high_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register.
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_sample_in = in_sample_ff;
      if (req_accept) begin
         in_valid_in  = 1'b1;
         in_sample_in = req_if.sample;
      end else if (in_consume) begin
         in_valid_in = 1'b0;
      end
   end

   // Accumulator update, including the sample now being consumed.
   always_comb begin
      sum_next    = sum_ff + SUM_W'(in_sample_ff);
      min_next    = (in_sample_ff < min_ff) ? in_sample_ff : min_ff;
      max_next    = (in_sample_ff > max_ff) ? in_sample_ff : max_ff;
      trimmed_sum = sum_next - SUM_W'(min_next) - SUM_W'(max_next);

      count_in      = count_ff;
      sum_in        = sum_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      mean_valid_in = mean_valid_ff;
      mean_in       = mean_ff;

      if (mean_move) begin
         mean_valid_in = 1'b0;
      end
      if (in_consume) begin
         if (window_end) begin
            count_in      = '0;
            sum_in        = '0;
            min_in        = '1;
            max_in        = '0;
            mean_valid_in = 1'b1;
            mean_in       = trimmed_sum[KEPT_LOG2 +: MEAN_W];
         end else begin
            count_in = count_ff + COUNT_W'(1);
            sum_in   = sum_next;
            min_in   = min_next;
            max_in   = max_next;
         end
      end
   end

   // Height conversion, grading and change detection.
   always_comb begin
      product = PROD_W'(mean_ff) * PROD_W'(HEIGHT_MUL);
      height  = product[HEIGHT_SHIFT +: HEIGHT_W];

      if (height <= thresh_low_ff) begin
         level = LEVEL_0;
      end else if (height <= thresh_mid_ff) begin
         level = LEVEL_1;
      end else if (height <= thresh_high_ff) begin
         level = LEVEL_2;
      end else begin
         level = LEVEL_3;
      end

      changed = first_done_ff && (level != prev_level_ff);

      rsp_valid_in   = rsp_valid_ff;
      rsp_mean_in    = rsp_mean_ff;
      rsp_height_in  = rsp_height_ff;
      rsp_level_in   = rsp_level_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_rose_in    = rsp_rose_ff;
      prev_level_in  = prev_level_ff;
      first_done_in  = first_done_ff;

      if (mean_move) begin
         rsp_valid_in   = 1'b1;
         rsp_mean_in    = mean_ff;
         rsp_height_in  = height;
         rsp_level_in   = level;
         rsp_changed_in = changed;
         rsp_rose_in    = changed && (level > prev_level_ff);
         prev_level_in  = level;
         first_done_in  = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_low_ff  <= THRESH_LOW_RESET;
         thresh_mid_ff  <= THRESH_MID_RESET;
         thresh_high_ff <= THRESH_HIGH_RESET;
         in_valid_ff    <= 1'b0;
         count_ff       <= '0;
         sum_ff         <= '0;
         min_ff         <= '1;
         max_ff         <= '0;
         mean_valid_ff  <= 1'b0;
         prev_level_ff  <= LEVEL_0;
         first_done_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         thresh_low_ff  <= thresh_low_in;
         thresh_mid_ff  <= thresh_mid_in;
         thresh_high_ff <= thresh_high_in;
         in_valid_ff    <= in_valid_in;
         count_ff       <= count_in;
         sum_ff         <= sum_in;
         min_ff         <= min_in;
         max_ff         <= max_in;
         mean_valid_ff  <= mean_valid_in;
         prev_level_ff  <= prev_level_in;
         first_done_ff  <= first_done_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_sample_ff   <= in_sample_in;
      mean_ff        <= mean_in;
      rsp_mean_ff    <= rsp_mean_in;
      rsp_height_ff  <= rsp_height_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_rose_ff    <= rsp_rose_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.mean_code     = rsp_mean_ff;
   assign rsp_if.height_cm     = rsp_height_ff;
   assign rsp_if.level         = rsp_level_ff;
   assign rsp_if.level_changed = rsp_changed_ff;
   assign rsp_if.level_rose    = rsp_rose_ff;

`ifndef ASSERT_OFF
   // The sample counter never runs past the last slot of a window.
   a_count_in_window: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_COUNT)
      else $error("sample counter beyond window length");

   // A rise is only reported together with a change.
   a_rose_needs_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rose_ff |-> rsp_changed_ff)
      else $error("level rose without level change");

   // Once a mean has been graded, later windows compare against history.
   a_first_done_set: assert property (@(posedge clock) disable iff (reset)
      mean_move |=> first_done_ff && rsp_valid_ff)
      else $error("graded window did not reach response register");

   // A completed window is never dropped while the mean register is busy.
   a_no_mean_overwrite: assert property (@(posedge clock) disable iff (reset)
      mean_valid_ff && !out_free |=> mean_valid_ff && $stable(mean_ff))
      else $error("pending mean overwritten");
`endif

endmodule
